@@ hdl/kvi_pkg.sv @@
// Shared types, constants and codes for the keyframe vertex interpolator.
`default_nettype none
package kvi_pkg;

    localparam int MAX_FRAMES = 512;
    localparam int FRAME_W    = $clog2(MAX_FRAMES);
    localparam int COUNT_W    = 10;
    localparam int PERIOD_W   = 16;
    localparam int FIRST_W    = 9;
    localparam int CFG_W      = 16;
    localparam int CFG_ADDR_W = 2;
    localparam int TIME_W     = 25;
    localparam int SUM_W      = 26;
    localparam int WEIGHT_W   = 17;
    localparam int KEY_W      = 32;
    localparam int VTX_W      = 24;
    localparam int POS_W      = 32;
    localparam int S_DATA_W   = 208;
    localparam int M_DATA_W   = 136;

    // shared multiplier operand and product widths
    localparam int MUL_A_W = 34;
    localparam int MUL_B_W = 25;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    // shared divider widths
    localparam int DIV_DVD_W = 33;
    localparam int DIV_DVS_W = 25;
    localparam int DIV_CNT_W = $clog2(DIV_DVD_W + 1);

    localparam logic [WEIGHT_W-1:0] WEIGHT_ONE = WEIGHT_W'(65536);

    localparam logic [CFG_ADDR_W-1:0] REG_FIRST  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COUNT  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_PERIOD = 2'd2;

    localparam logic [1:0] FUNC_TIME = 2'd0;
    localparam logic [1:0] FUNC_KEY  = 2'd1;
    localparam logic [1:0] FUNC_VTX  = 2'd2;
    localparam logic [1:0] FUNC_NONE = 2'd3;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;
    localparam logic [1:0] AXIS_NONE = 2'd3;

    // vertex micro steps, one per cycle for each axis
    localparam logic [3:0] VS_SCALE_A  = 4'd0;
    localparam logic [3:0] VS_SCALE_B  = 4'd1;
    localparam logic [3:0] VS_OFFS_A   = 4'd2;
    localparam logic [3:0] VS_OFFS_B   = 4'd3;
    localparam logic [3:0] VS_VERT_A   = 4'd4;
    localparam logic [3:0] VS_VERT_B   = 4'd5;
    localparam logic [3:0] VS_VERT_SUM = 4'd6;
    localparam logic [3:0] VS_PRODUCT  = 4'd7;
    localparam logic [3:0] VS_ROUND    = 4'd8;
    localparam logic [3:0] VS_STORE    = 4'd9;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LEN,
        ST_WRAP_WAIT,
        ST_FRAME,
        ST_FRAME_WAIT,
        ST_WGT,
        ST_WGT_WAIT,
        ST_TIME_OUT,
        ST_VTX,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic                 start;
        logic [DIV_DVD_W-1:0] dividend;
        logic [DIV_DVS_W-1:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic                 done;
        logic [DIV_DVD_W-1:0] quot;
        logic [DIV_DVS_W-1:0] rem;
    } div_rsp_t;

endpackage
`default_nettype wire

@@ hdl/kvi_mul.sv @@
// Shared signed multiplier with registered product.
`default_nettype none
module kvi_mul (
    input  wire logic                                 aclk,
    input  wire logic signed [kvi_pkg::MUL_A_W-1:0]   op_a,
    input  wire logic signed [kvi_pkg::MUL_B_W-1:0]   op_b,
    output logic signed      [kvi_pkg::MUL_P_W-1:0]   prod
);

    logic signed [kvi_pkg::MUL_P_W-1:0] prod_reg;
    logic signed [kvi_pkg::MUL_P_W-1:0] prod_next;

    assign prod_next = kvi_pkg::MUL_P_W'(op_a) * kvi_pkg::MUL_P_W'(op_b);

    always_ff @(posedge aclk) begin
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule
`default_nettype wire

@@ hdl/kvi_div.sv @@
// Shared restoring divider, one quotient bit per cycle.
`default_nettype none
module kvi_div (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire kvi_pkg::div_req_t req,
    output kvi_pkg::div_rsp_t      rsp
);

    logic                            busy_reg, busy_next;
    logic                            done_reg, done_next;
    logic [kvi_pkg::DIV_CNT_W-1:0]   cnt_reg, cnt_next;
    logic [kvi_pkg::DIV_DVS_W-1:0]   rem_reg, rem_next;
    logic [kvi_pkg::DIV_DVD_W-1:0]   quo_reg, quo_next;
    logic [kvi_pkg::DIV_DVS_W-1:0]   dvs_reg, dvs_next;
    logic [kvi_pkg::DIV_DVS_W:0]     shifted;
    logic [kvi_pkg::DIV_DVS_W:0]     diff;

    always_comb begin
        shifted   = {rem_reg, quo_reg[kvi_pkg::DIV_DVD_W-1]};
        diff      = shifted - {1'b0, dvs_reg};
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (req.start) begin
            busy_next = 1'b1;
            cnt_next  = kvi_pkg::DIV_CNT_W'(kvi_pkg::DIV_DVD_W);
            rem_next  = '0;
            quo_next  = req.dividend;
            dvs_next  = req.divisor;
        end else if (busy_reg) begin
            // keep the partial remainder only when the trial subtract goes negative
            if (!diff[kvi_pkg::DIV_DVS_W]) begin
                rem_next = diff[kvi_pkg::DIV_DVS_W-1:0];
            end else begin
                rem_next = shifted[kvi_pkg::DIV_DVS_W-1:0];
            end
            quo_next = {quo_reg[kvi_pkg::DIV_DVD_W-2:0], ~diff[kvi_pkg::DIV_DVS_W]};
            cnt_next = cnt_reg - kvi_pkg::DIV_CNT_W'(1);
            if (cnt_reg == kvi_pkg::DIV_CNT_W'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    assign rsp.done = done_reg;
    assign rsp.quot = quo_reg;
    assign rsp.rem  = rem_reg;

endmodule
`default_nettype wire

@@ hdl/keyframe_vertex_interpolator.sv @@
// Top level: sequencer, key store and result register of the keyframe interpolator.
//
// Input transfers arrive on s_tvalid/s_tready with the function code on s_tuser.
// A time item adds ticks to the animation time, wraps it into the cycle and
// returns both key frames and the Q1.16 blend weight. A key item stores the
// scale and offset of one axis. A vertex item blends two byte vertices with the
// stored weight and returns the Q16.16 position on m_tdata.
// The block takes one item at a time; s_tready is high only while idle.
// Vertex items take ten steps per axis on the shared multiplier; time items
// take up to three passes of the 33-step serial divider, the wrap pass only
// when the time wraps. Key and unknown items go straight to the done state.
// The configuration port writes registers at any edge with cfg_wr_en high and
// must only be used while idle.
// Reset clears the animation time, the weight and the registers to their
// defaults; the key store holds nothing valid until written.
// When the receiver stalls, the result is held on m_tdata; a later item waits
// in the done state until that result is taken before returning to idle.
`default_nettype none
module keyframe_vertex_interpolator (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              cfg_wr_en,
    input  wire logic [kvi_pkg::CFG_ADDR_W-1:0]    cfg_addr,
    input  wire logic [kvi_pkg::CFG_W-1:0]         cfg_wr_data,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // tick_delta, axis, scale_first, offset_first, scale_second, offset_second,
    // packed_vertex_first, packed_vertex_second, zero fill
    input  wire logic [kvi_pkg::S_DATA_W-1:0]      s_tdata,
    // func
    input  wire logic [1:0]                        s_tuser,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // key_frame_first, key_frame_second, blend_weight, pos_x, pos_y, pos_z, zero fill
    output logic [kvi_pkg::M_DATA_W-1:0]           m_tdata
);

    localparam int ACC_W = kvi_pkg::MUL_P_W + 1;
    localparam int VAL_W = ACC_W - 16;

    kvi_pkg::state_t state_reg, state_next;

    logic [kvi_pkg::FIRST_W-1:0]   first_reg;
    logic [kvi_pkg::COUNT_W-1:0]   count_reg;
    logic [kvi_pkg::PERIOD_W-1:0]  period_reg;
    logic [kvi_pkg::TIME_W-1:0]    anim_reg, anim_next;
    logic [kvi_pkg::WEIGHT_W-1:0]  weight_reg, weight_next;
    logic [kvi_pkg::SUM_W-1:0]     t_reg, t_next;
    logic [kvi_pkg::COUNT_W-1:0]   k_reg, k_next;
    logic [kvi_pkg::PERIOD_W-1:0]  r_reg, r_next;
    logic [kvi_pkg::VTX_W-1:0]     pva_reg, pva_next;
    logic [kvi_pkg::VTX_W-1:0]     pvb_reg, pvb_next;
    logic [3:0]                    step_reg, step_next;
    logic [1:0]                    axis_reg, axis_next;
    logic signed [kvi_pkg::MUL_P_W-1:0] acc_reg, acc_next;
    logic signed [kvi_pkg::MUL_A_W-1:0] sc_reg, sc_next;
    logic [kvi_pkg::MUL_B_W-1:0]   vq_reg, vq_next;
    logic signed [VAL_W-1:0]       val_reg, val_next;

    logic [kvi_pkg::FRAME_W-1:0]   res_kf1_reg, res_kf1_next;
    logic [kvi_pkg::FRAME_W-1:0]   res_kf2_reg, res_kf2_next;
    logic [kvi_pkg::WEIGHT_W-1:0]  res_bw_reg, res_bw_next;
    logic [kvi_pkg::POS_W-1:0]     res_x_reg, res_x_next;
    logic [kvi_pkg::POS_W-1:0]     res_y_reg, res_y_next;
    logic [kvi_pkg::POS_W-1:0]     res_z_reg, res_z_next;
    logic                          m_valid_reg, m_valid_next;
    logic [kvi_pkg::M_DATA_W-1:0]  m_data_reg, m_data_next;

    logic signed [kvi_pkg::KEY_W-1:0] key_sf_reg [3];
    logic signed [kvi_pkg::KEY_W-1:0] key_of_reg [3];
    logic signed [kvi_pkg::KEY_W-1:0] key_ss_reg [3];
    logic signed [kvi_pkg::KEY_W-1:0] key_os_reg [3];

    logic                          s_xfer;
    logic                          out_free;
    logic                          key_we;
    logic [kvi_pkg::COUNT_W-1:0]   count_eff;
    logic [kvi_pkg::PERIOD_W-1:0]  period_eff;
    logic [kvi_pkg::WEIGHT_W-1:0]  inv_weight;
    logic [7:0]                    byte_a, byte_b;
    logic signed [kvi_pkg::MUL_A_W-1:0] op_a;
    logic signed [kvi_pkg::MUL_B_W-1:0] op_b;
    logic signed [kvi_pkg::MUL_P_W-1:0] prod;
    logic signed [ACC_W-1:0]       round_sum;
    logic signed [VAL_W:0]         val_signed;
    logic [kvi_pkg::POS_W-1:0]     val_sat;
    logic [kvi_pkg::FRAME_W-1:0]   frame_a, frame_b;
    kvi_pkg::div_req_t             div_req;
    kvi_pkg::div_rsp_t             div_rsp;

    kvi_mul u_mul (
        .aclk (aclk),
        .op_a (op_a),
        .op_b (op_b),
        .prod (prod)
    );

    kvi_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (div_req),
        .rsp     (div_rsp)
    );

    assign s_tready = (state_reg == kvi_pkg::ST_IDLE) && aresetn;
    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // clamp the cycle registers to their legal ranges
    always_comb begin
        if (count_reg == '0) begin
            count_eff = kvi_pkg::COUNT_W'(1);
        end else if (count_reg > kvi_pkg::COUNT_W'(kvi_pkg::MAX_FRAMES)) begin
            count_eff = kvi_pkg::COUNT_W'(kvi_pkg::MAX_FRAMES);
        end else begin
            count_eff = count_reg;
        end
        period_eff = (period_reg == '0) ? kvi_pkg::PERIOD_W'(1) : period_reg;
    end

    assign inv_weight = kvi_pkg::WEIGHT_ONE - weight_reg;

    always_comb begin
        unique case (axis_reg)
            kvi_pkg::AXIS_X: begin
                byte_a = pva_reg[7:0];
                byte_b = pvb_reg[7:0];
            end
            kvi_pkg::AXIS_Y: begin
                byte_a = pva_reg[15:8];
                byte_b = pvb_reg[15:8];
            end
            default: begin
                byte_a = pva_reg[23:16];
                byte_b = pvb_reg[23:16];
            end
        endcase
    end

    // shared multiplier operand select
    always_comb begin
        op_a = '0;
        op_b = '0;
        if (state_reg == kvi_pkg::ST_IDLE) begin
            op_a = $signed({{(kvi_pkg::MUL_A_W - kvi_pkg::COUNT_W){1'b0}}, count_eff});
            op_b = $signed({{(kvi_pkg::MUL_B_W - kvi_pkg::PERIOD_W){1'b0}}, period_eff});
        end else if (state_reg == kvi_pkg::ST_VTX) begin
            unique case (step_reg)
                kvi_pkg::VS_SCALE_A: begin
                    op_a = kvi_pkg::MUL_A_W'(key_sf_reg[axis_reg]);
                    op_b = $signed({8'b0, inv_weight});
                end
                kvi_pkg::VS_SCALE_B: begin
                    op_a = kvi_pkg::MUL_A_W'(key_ss_reg[axis_reg]);
                    op_b = $signed({8'b0, weight_reg});
                end
                kvi_pkg::VS_OFFS_A: begin
                    op_a = kvi_pkg::MUL_A_W'(key_of_reg[axis_reg]);
                    op_b = $signed({8'b0, inv_weight});
                end
                kvi_pkg::VS_OFFS_B: begin
                    op_a = kvi_pkg::MUL_A_W'(key_os_reg[axis_reg]);
                    op_b = $signed({8'b0, weight_reg});
                end
                kvi_pkg::VS_VERT_A: begin
                    op_a = $signed({26'b0, byte_a});
                    op_b = $signed({8'b0, inv_weight});
                end
                kvi_pkg::VS_VERT_B: begin
                    op_a = $signed({26'b0, byte_b});
                    op_b = $signed({8'b0, weight_reg});
                end
                kvi_pkg::VS_PRODUCT: begin
                    op_a = sc_reg;
                    op_b = $signed(vq_reg);
                end
                default: begin
                    op_a = '0;
                    op_b = '0;
                end
            endcase
        end
    end

    // round to nearest at bit 16, ties upward
    assign round_sum = ACC_W'(acc_reg) + ACC_W'(prod) + ACC_W'(32768);

    always_comb begin
        if (axis_reg == kvi_pkg::AXIS_Y) begin
            val_signed = -(VAL_W + 1)'(val_reg);
        end else begin
            val_signed = (VAL_W + 1)'(val_reg);
        end
        if (val_signed > (VAL_W + 1)'(64'sd2147483647)) begin
            val_sat = 32'h7FFF_FFFF;
        end else if (val_signed < -(VAL_W + 1)'(64'sd2147483648)) begin
            val_sat = 32'h8000_0000;
        end else begin
            val_sat = val_signed[kvi_pkg::POS_W-1:0];
        end
    end

    always_comb begin
        frame_a = first_reg + k_reg[kvi_pkg::FRAME_W-1:0];
        if ((k_reg + kvi_pkg::COUNT_W'(1)) < count_eff) begin
            frame_b = frame_a + kvi_pkg::FRAME_W'(1);
        end else begin
            frame_b = first_reg;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kvi_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    if (s_tuser == kvi_pkg::FUNC_TIME) begin
                        state_next = kvi_pkg::ST_LEN;
                    end else if (s_tuser == kvi_pkg::FUNC_VTX) begin
                        state_next = kvi_pkg::ST_VTX;
                    end else begin
                        state_next = kvi_pkg::ST_DONE;
                    end
                end
            end
            kvi_pkg::ST_LEN: begin
                if (t_reg > kvi_pkg::SUM_W'(prod[kvi_pkg::TIME_W-1:0])) begin
                    state_next = kvi_pkg::ST_WRAP_WAIT;
                end else begin
                    state_next = kvi_pkg::ST_FRAME;
                end
            end
            kvi_pkg::ST_WRAP_WAIT: begin
                if (div_rsp.done) state_next = kvi_pkg::ST_FRAME;
            end
            kvi_pkg::ST_FRAME: begin
                if (t_reg == '0) begin
                    state_next = kvi_pkg::ST_TIME_OUT;
                end else begin
                    state_next = kvi_pkg::ST_FRAME_WAIT;
                end
            end
            kvi_pkg::ST_FRAME_WAIT: begin
                if (div_rsp.done) state_next = kvi_pkg::ST_WGT;
            end
            kvi_pkg::ST_WGT: begin
                state_next = kvi_pkg::ST_WGT_WAIT;
            end
            kvi_pkg::ST_WGT_WAIT: begin
                if (div_rsp.done) state_next = kvi_pkg::ST_TIME_OUT;
            end
            kvi_pkg::ST_TIME_OUT: begin
                state_next = kvi_pkg::ST_DONE;
            end
            kvi_pkg::ST_VTX: begin
                if (step_reg == kvi_pkg::VS_STORE && axis_reg == kvi_pkg::AXIS_Z) begin
                    state_next = kvi_pkg::ST_DONE;
                end
            end
            kvi_pkg::ST_DONE: begin
                if (out_free) state_next = kvi_pkg::ST_IDLE;
            end
            default: state_next = kvi_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        anim_next    = anim_reg;
        weight_next  = weight_reg;
        t_next       = t_reg;
        k_next       = k_reg;
        r_next       = r_reg;
        pva_next     = pva_reg;
        pvb_next     = pvb_reg;
        step_next    = step_reg;
        axis_next    = axis_reg;
        acc_next     = acc_reg;
        sc_next      = sc_reg;
        vq_next      = vq_reg;
        val_next     = val_reg;
        res_kf1_next = res_kf1_reg;
        res_kf2_next = res_kf2_reg;
        res_bw_next  = res_bw_reg;
        res_x_next   = res_x_reg;
        res_y_next   = res_y_reg;
        res_z_next   = res_z_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        key_we       = 1'b0;
        div_req      = '0;

        unique case (state_reg)
            kvi_pkg::ST_IDLE: begin
                if (s_xfer) begin
                    t_next       = kvi_pkg::SUM_W'(anim_reg) + kvi_pkg::SUM_W'(s_tdata[23:0]);
                    pva_next     = s_tdata[177:154];
                    pvb_next     = s_tdata[201:178];
                    step_next    = kvi_pkg::VS_SCALE_A;
                    axis_next    = kvi_pkg::AXIS_X;
                    res_kf1_next = '0;
                    res_kf2_next = '0;
                    res_bw_next  = '0;
                    res_x_next   = '0;
                    res_y_next   = '0;
                    res_z_next   = '0;
                    key_we = (s_tuser == kvi_pkg::FUNC_KEY) &&
                             (s_tdata[25:24] != kvi_pkg::AXIS_NONE);
                end
            end
            kvi_pkg::ST_LEN: begin
                // prod holds the cycle length here
                if (t_reg > kvi_pkg::SUM_W'(prod[kvi_pkg::TIME_W-1:0])) begin
                    div_req.start    = 1'b1;
                    div_req.dividend = kvi_pkg::DIV_DVD_W'(t_reg - kvi_pkg::SUM_W'(1));
                    div_req.divisor  = prod[kvi_pkg::DIV_DVS_W-1:0];
                end
            end
            kvi_pkg::ST_WRAP_WAIT: begin
                if (div_rsp.done) begin
                    t_next = kvi_pkg::SUM_W'(div_rsp.rem) + kvi_pkg::SUM_W'(1);
                end
            end
            kvi_pkg::ST_FRAME: begin
                anim_next = t_reg[kvi_pkg::TIME_W-1:0];
                if (t_reg == '0) begin
                    k_next      = '0;
                    weight_next = '0;
                end else begin
                    div_req.start    = 1'b1;
                    div_req.dividend = kvi_pkg::DIV_DVD_W'(t_reg - kvi_pkg::SUM_W'(1));
                    div_req.divisor  = kvi_pkg::DIV_DVS_W'(period_eff);
                end
            end
            kvi_pkg::ST_FRAME_WAIT: begin
                if (div_rsp.done) begin
                    k_next = div_rsp.quot[kvi_pkg::COUNT_W-1:0];
                    r_next = div_rsp.rem[kvi_pkg::PERIOD_W-1:0] + kvi_pkg::PERIOD_W'(1);
                end
            end
            kvi_pkg::ST_WGT: begin
                div_req.start    = 1'b1;
                div_req.dividend = kvi_pkg::DIV_DVD_W'({r_reg, 16'b0});
                div_req.divisor  = kvi_pkg::DIV_DVS_W'(period_eff);
            end
            kvi_pkg::ST_WGT_WAIT: begin
                if (div_rsp.done) begin
                    weight_next = div_rsp.quot[kvi_pkg::WEIGHT_W-1:0];
                end
            end
            kvi_pkg::ST_TIME_OUT: begin
                res_kf1_next = frame_a;
                res_kf2_next = frame_b;
                res_bw_next  = weight_reg;
            end
            kvi_pkg::ST_VTX: begin
                step_next = step_reg + 4'd1;
                unique case (step_reg)
                    kvi_pkg::VS_SCALE_B: acc_next = prod;
                    kvi_pkg::VS_OFFS_A:  sc_next  = round_sum[49:16];
                    kvi_pkg::VS_OFFS_B:  acc_next = prod;
                    kvi_pkg::VS_VERT_A:  acc_next = acc_reg + prod;
                    kvi_pkg::VS_VERT_B:  vq_next  = prod[kvi_pkg::MUL_B_W-1:0];
                    kvi_pkg::VS_VERT_SUM: begin
                        vq_next = vq_reg + prod[kvi_pkg::MUL_B_W-1:0];
                    end
                    kvi_pkg::VS_ROUND: val_next = round_sum[ACC_W-1:16];
                    kvi_pkg::VS_STORE: begin
                        step_next = kvi_pkg::VS_SCALE_A;
                        axis_next = axis_reg + 2'd1;
                        // y and z swap places on the way out
                        if (axis_reg == kvi_pkg::AXIS_X) begin
                            res_x_next = val_sat;
                        end else if (axis_reg == kvi_pkg::AXIS_Y) begin
                            res_z_next = val_sat;
                        end else begin
                            res_y_next = val_sat;
                        end
                    end
                    default: begin
                    end
                endcase
            end
            kvi_pkg::ST_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {5'b0, res_z_reg, res_y_reg, res_x_reg, res_bw_reg,
                                    res_kf2_reg, res_kf1_reg};
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= kvi_pkg::ST_IDLE;
            first_reg   <= '0;
            count_reg   <= kvi_pkg::COUNT_W'(1);
            period_reg  <= kvi_pkg::PERIOD_W'(100);
            anim_reg    <= '0;
            weight_reg  <= '0;
            step_reg    <= kvi_pkg::VS_SCALE_A;
            axis_reg    <= kvi_pkg::AXIS_X;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            anim_reg    <= anim_next;
            weight_reg  <= weight_next;
            step_reg    <= step_next;
            axis_reg    <= axis_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_addr)
                    kvi_pkg::REG_FIRST:  first_reg  <= cfg_wr_data[kvi_pkg::FIRST_W-1:0];
                    kvi_pkg::REG_COUNT:  count_reg  <= cfg_wr_data[kvi_pkg::COUNT_W-1:0];
                    kvi_pkg::REG_PERIOD: period_reg <= cfg_wr_data;
                    default: begin
                    end
                endcase
            end
        end
        t_reg       <= t_next;
        k_reg       <= k_next;
        r_reg       <= r_next;
        pva_reg     <= pva_next;
        pvb_reg     <= pvb_next;
        acc_reg     <= acc_next;
        sc_reg      <= sc_next;
        vq_reg      <= vq_next;
        val_reg     <= val_next;
        res_kf1_reg <= res_kf1_next;
        res_kf2_reg <= res_kf2_next;
        res_bw_reg  <= res_bw_next;
        res_x_reg   <= res_x_next;
        res_y_reg   <= res_y_next;
        res_z_reg   <= res_z_next;
        m_data_reg  <= m_data_next;
        if (key_we) begin
            key_sf_reg[s_tdata[25:24]] <= s_tdata[57:26];
            key_of_reg[s_tdata[25:24]] <= s_tdata[89:58];
            key_ss_reg[s_tdata[25:24]] <= s_tdata[121:90];
            key_os_reg[s_tdata[25:24]] <= s_tdata[153:122];
        end
    end

endmodule
`default_nettype wire

@@ hdl/kvi_checker.sv @@
// Port-level checks of the keyframe interpolator, bound to the top level.
`default_nettype none
module kvi_checker (
    input wire logic                             aclk,
    input wire logic                             aresetn,
    input wire logic                             s_tvalid,
    input wire logic                             s_tready,
    input wire logic                             m_tvalid,
    input wire logic                             m_tready,
    input wire logic [kvi_pkg::M_DATA_W-1:0]     m_tdata
);

    // the block takes one item and is busy in the cycle after the transfer
    a_busy_after_xfer: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after an input transfer");

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_weight_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[34:18] <= 17'd65536)
        else $error("blend weight above one");

    // a result carries either frame timing or a position, never both
    a_one_kind: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[34:0] == '0) || (m_tdata[130:35] == '0))
        else $error("time and vertex fields both set");

    a_reset_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind keyframe_vertex_interpolator kvi_checker u_kvi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
`default_nettype wire
